// File: rtl/streaming_topk_selector_defines.svh
// assertion macros for the streaming top-k selector
`ifndef STREAMING_TOPK_SELECTOR_DEFINES_SVH
`define STREAMING_TOPK_SELECTOR_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define STK_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define STK_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/stk_pkg.sv
// package: sizes, register map and payload types of the streaming top-k selector
`timescale 1ns / 1ps

package stk_pkg;

   localparam int MAX_KEEP   = 8;
   localparam int MAX_ITEMS  = 256;

   localparam int SCORE_W    = 32;
   localparam int INDEX_W    = 8;
   localparam int KEEP_CFG_W = 4;
   localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
   localparam int REM_W      = $clog2(MAX_KEEP + 1);

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0]  REG_KEEP_COUNT = '0;
   localparam logic [KEEP_CFG_W-1:0] KEEP_RESET     = 4'd4;

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic                      last_item;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0]        rank_index;
      logic signed [SCORE_W-1:0] rank_score;
      logic                      rank_empty;
      logic                      set_overflow;
      logic                      last_rank;
   } rsp_type;

endpackage

// File: rtl/streaming_topk_selector.sv
// streaming top-k selector: sorted insertion list, result buffer and csr port
// latency: a request marked last shows its first rank in the cycle after acceptance,
//   then one rank per unstalled cycle, keep_count ranks in all (0 counts as 1, above 8 as 8)
// throughput: one request per cycle; a last-marked request waits while an earlier set's
//   ranks are in the result buffer, unless only the final one is left and leaves that cycle
// reset (synchronous): clears the list, item count and overflow flag; keep_count reads 4
`timescale 1ns / 1ps
`include "streaming_topk_selector_defines.svh"

module streaming_topk_selector
   import stk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // held sorted list
   logic signed [SCORE_W-1:0] held_score_ff [MAX_KEEP];
   logic signed [SCORE_W-1:0] held_score_in [MAX_KEEP];
   logic [INDEX_W-1:0]        held_index_ff [MAX_KEEP];
   logic [INDEX_W-1:0]        held_index_in [MAX_KEEP];
   logic [MAX_KEEP-1:0]       held_full_ff;
   logic [MAX_KEEP-1:0]       held_full_in;

   // list after this request's insertion
   logic signed [SCORE_W-1:0] list_score [MAX_KEEP];
   logic [INDEX_W-1:0]        list_index [MAX_KEEP];
   logic [MAX_KEEP-1:0]       list_full;

   logic [CNT_W-1:0]          item_cnt_ff, item_cnt_in;
   logic                      overflow_ff, overflow_in;

   // result buffer, rank 0 at the head
   logic signed [SCORE_W-1:0] snap_score_ff [MAX_KEEP];
   logic signed [SCORE_W-1:0] snap_score_in [MAX_KEEP];
   logic [INDEX_W-1:0]        snap_index_ff [MAX_KEEP];
   logic [INDEX_W-1:0]        snap_index_in [MAX_KEEP];
   logic [MAX_KEEP-1:0]       snap_full_ff, snap_full_in;
   logic                      snap_ovf_ff, snap_ovf_in;
   logic [REM_W-1:0]          rem_ff, rem_in;

   logic [KEEP_CFG_W-1:0]     keep_count_ff, keep_count_in;
   logic [REM_W-1:0]          keep_eff;

   logic                      req_acc, rsp_acc, ins_en, set_end;
   logic [MAX_KEEP-1:0]       ge, hit;
   logic                      csr_wr;
   logic                      held_gap;

   assign req_acc = req_valid && !req_stall;
   assign rsp_acc = rsp_valid && !rsp_stall;
   assign set_end = req_acc && req_data.last_item;
   assign ins_en  = req_acc && (item_cnt_ff < CNT_W'(MAX_ITEMS));

   // a new set may load once only the final rank of the previous one is left and leaves now
   assign req_stall = req_data.last_item && (rem_ff != '0)
                      && !((rem_ff == REM_W'(1)) && !rsp_stall);

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[CSR_ADDR_W-1:2] == REG_KEEP_COUNT);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[CSR_ADDR_W-1:2] == REG_KEEP_COUNT)
                       ? CSR_DATA_W'(keep_count_ff) : '0;

   always_comb begin
      if (keep_count_ff == '0) begin
         keep_eff = REM_W'(1);
      end else if (32'(keep_count_ff) > MAX_KEEP) begin
         keep_eff = REM_W'(MAX_KEEP);
      end else begin
         keep_eff = REM_W'(keep_count_ff);
      end
   end

   // insertion: first slot that is empty or strictly beaten takes the score
   always_comb begin
      for (int j = 0; j < MAX_KEEP; j++) begin
         ge[j] = ins_en && (!held_full_ff[j] || (req_data.score > held_score_ff[j]));
      end
      hit[0] = ge[0];
      for (int j = 1; j < MAX_KEEP; j++) begin
         hit[j] = hit[j-1] | ge[j];
      end

      list_score[0] = hit[0] ? req_data.score : held_score_ff[0];
      list_index[0] = hit[0] ? INDEX_W'(item_cnt_ff) : held_index_ff[0];
      list_full[0]  = hit[0] | held_full_ff[0];
      for (int j = 1; j < MAX_KEEP; j++) begin
         if (hit[j] && !hit[j-1]) begin
            list_score[j] = req_data.score;
            list_index[j] = INDEX_W'(item_cnt_ff);
            list_full[j]  = 1'b1;
         end else if (hit[j]) begin
            list_score[j] = held_score_ff[j-1];
            list_index[j] = held_index_ff[j-1];
            list_full[j]  = held_full_ff[j-1];
         end else begin
            list_score[j] = held_score_ff[j];
            list_index[j] = held_index_ff[j];
            list_full[j]  = held_full_ff[j];
         end
      end
   end

   always_comb begin
      held_score_in = list_score;
      held_index_in = list_index;
      held_full_in  = set_end ? '0 : list_full;

      item_cnt_in = item_cnt_ff;
      overflow_in = overflow_ff;
      if (set_end) begin
         item_cnt_in = '0;
         overflow_in = 1'b0;
      end else if (ins_en) begin
         item_cnt_in = item_cnt_ff + CNT_W'(1);
      end else if (req_acc) begin
         overflow_in = 1'b1;
      end

      snap_score_in = snap_score_ff;
      snap_index_in = snap_index_ff;
      snap_full_in  = snap_full_ff;
      snap_ovf_in   = snap_ovf_ff;
      rem_in        = rem_ff;
      if (set_end) begin
         snap_score_in = list_score;
         snap_index_in = list_index;
         snap_full_in  = list_full;
         snap_ovf_in   = overflow_ff || !ins_en;
         rem_in        = keep_eff;
      end else if (rsp_acc) begin
         for (int j = 0; j < MAX_KEEP - 1; j++) begin
            snap_score_in[j] = snap_score_ff[j+1];
            snap_index_in[j] = snap_index_ff[j+1];
         end
         snap_full_in = snap_full_ff >> 1;
         rem_in       = rem_ff - REM_W'(1);
      end

      keep_count_in = csr_wr ? csr_pwdata[KEEP_CFG_W-1:0] : keep_count_ff;
   end

   always_ff @(posedge clock) begin
      held_score_ff <= held_score_in;
      held_index_ff <= held_index_in;
      snap_score_ff <= snap_score_in;
      snap_index_ff <= snap_index_in;
      snap_full_ff  <= snap_full_in;
      snap_ovf_ff   <= snap_ovf_in;
      if (reset) begin
         held_full_ff  <= '0;
         item_cnt_ff   <= '0;
         overflow_ff   <= 1'b0;
         rem_ff        <= '0;
         keep_count_ff <= KEEP_RESET;
      end else begin
         held_full_ff  <= held_full_in;
         item_cnt_ff   <= item_cnt_in;
         overflow_ff   <= overflow_in;
         rem_ff        <= rem_in;
         keep_count_ff <= keep_count_in;
      end
   end

   assign rsp_valid              = (rem_ff != '0);
   assign rsp_data.rank_index    = snap_full_ff[0] ? snap_index_ff[0] : '0;
   assign rsp_data.rank_score    = snap_full_ff[0] ? snap_score_ff[0] : '0;
   assign rsp_data.rank_empty    = !snap_full_ff[0];
   assign rsp_data.set_overflow  = snap_ovf_ff;
   assign rsp_data.last_rank     = (rem_ff == REM_W'(1));

   // filled slots always sit at the top of the list
   assign held_gap = (((held_full_ff + MAX_KEEP'(1)) & held_full_ff) != '0);

   `STK_ASSERT_NEXT(a_set_end_gives_rank, set_end, rsp_valid, "no rank after end of set")
   `STK_ASSERT_NEXT(a_ranks_continue, rsp_acc && !rsp_data.last_rank, rsp_valid, "ranks cut short")
   `STK_ASSERT_NOW(a_list_packed, 1'b1, !held_gap, "hole in held list")
   `STK_ASSERT_NOW(a_count_bound, 1'b1, item_cnt_ff <= CNT_W'(MAX_ITEMS), "item count past limit")

endmodule

// File: tb/streaming_topk_selector_tb.sv
// testbench for the streaming top-k selector: queued request driver, rank predictor, rank checker
`timescale 1ns / 1ps

module streaming_topk_selector_tb;
   import stk_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 10;
   localparam int HOLD_CYCLES   = 150;
   localparam int PHASE_ITEMS   = 3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 1'b1;

   typedef enum int {SCORE_WIDE, SCORE_NARROW, SCORE_EDGE, SCORE_RAMP} score_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predictor state
   logic signed [SCORE_W-1:0] held_score [MAX_KEEP];
   logic [INDEX_W-1:0]        held_index [MAX_KEEP];
   logic                      held_full  [MAX_KEEP];
   int                        item_count = 0;
   logic                      set_over = 1'b0;
   logic [KEEP_CFG_W-1:0]     keep_cfg = KEEP_RESET;

   req_type pending_requests [$];
   rsp_type expected_ranks [$];

   int mismatches = 0;
   int cycle_count = 0;
   int idle_pct = 11;
   int stall_pct = 11;
   int hold_starts = 0;
   int hold_seen = 0;
   int hold_left = 0;

   streaming_topk_selector i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic clear_list();
      for (int j = 0; j < MAX_KEEP; j++) begin
         held_score[j] = '0;
         held_index[j] = '0;
         held_full[j]  = 1'b0;
      end
      item_count = 0;
      set_over   = 1'b0;
   endtask

   // sorted insertion; on a last-marked request the ranks go to the expected queue
   task automatic insert_and_rank(req_type r);
      int     slot;
      int     k;
      rsp_type rank;
      slot = -1;
      if (item_count < MAX_ITEMS) begin
         for (int j = 0; j < MAX_KEEP; j++) begin
            if (slot < 0 && (!held_full[j] || r.score > held_score[j])) slot = j;
         end
         if (slot >= 0) begin
            for (int j = MAX_KEEP - 1; j > slot; j--) begin
               held_score[j] = held_score[j-1];
               held_index[j] = held_index[j-1];
               held_full[j]  = held_full[j-1];
            end
            held_score[slot] = r.score;
            held_index[slot] = item_count[INDEX_W-1:0];
            held_full[slot]  = 1'b1;
         end
         item_count++;
      end else begin
         set_over = 1'b1;
      end
      if (r.last_item) begin
         k = keep_cfg;
         if (k < 1) k = 1;
         if (k > MAX_KEEP) k = MAX_KEEP;
         for (int j = 0; j < k; j++) begin
            rank.rank_index   = held_full[j] ? held_index[j] : '0;
            rank.rank_score   = held_full[j] ? held_score[j] : '0;
            rank.rank_empty   = !held_full[j];
            rank.set_overflow = set_over;
            rank.last_rank    = (j == k - 1);
            expected_ranks.push_back(rank);
         end
         clear_list();
      end
   endtask

   task automatic report_mismatch(string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      mismatches++;
   endtask

   // driver: holds the offered request until it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin : drive
         logic taken;
         taken = req_valid && !req_stall;
         if (taken) begin
            insert_and_rank(req_data);
            void'(pending_requests.pop_front());
         end
         if (!req_valid || taken) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
               req_valid <= 1'b1;
               req_data  <= pending_requests[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_starts != hold_seen) begin
         hold_seen <= hold_starts;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin : check
         rsp_type want;
         if (expected_ranks.size() == 0) begin
            report_mismatch($sformatf("unexpected rank %p", rsp_data));
         end else begin
            want = expected_ranks.pop_front();
            if (rsp_data.rank_index !== want.rank_index ||
                rsp_data.rank_score !== want.rank_score ||
                rsp_data.rank_empty !== want.rank_empty ||
                rsp_data.set_overflow !== want.set_overflow ||
                rsp_data.last_rank !== want.last_rank)
               report_mismatch($sformatf("got %p, want %p", rsp_data, want));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** streaming_topk_selector: FAILED **");
         $finish;
      end
   end

   function automatic logic signed [SCORE_W-1:0] pick_score(score_mode_type mode, int pos);
      logic signed [SCORE_W-1:0] s;
      case (mode)
         SCORE_NARROW: s = $signed($urandom_range(8)) - 4;
         SCORE_EDGE: begin
            case ($urandom_range(3))
               0: s = 32'sh7FFF_FFFF;
               1: s = 32'sh8000_0000;
               2: s = '0;
               default: s = -1;
            endcase
         end
         SCORE_RAMP: s = (pos <<< 8) + $urandom_range(255);
         default: s = $urandom;
      endcase
      return s;
   endfunction

   task automatic queue_item(logic signed [SCORE_W-1:0] s, logic last);
      req_type item;
      item.score     = s;
      item.last_item = last;
      pending_requests.push_back(item);
   endtask

   task automatic queue_set(int len, score_mode_type mode);
      for (int p = 0; p < len; p++) queue_item(pick_score(mode, p), p == len - 1);
   endtask

   task automatic wait_idle();
      while (pending_requests.size() != 0 || expected_ranks.size() != 0 || req_valid)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [KEEP_CFG_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= {(CSR_DATA_W - KEEP_CFG_W)'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_KEEP_COUNT) keep_cfg = value;
      @(negedge clock);
   endtask

   initial begin : stimulus
      logic [KEEP_CFG_W-1:0] keep_plan [7];
      int phase_count;
      int len;
      keep_plan = '{4'd1, 4'd15, 4'd0, 4'd8, 4'd3, 4'd6, 4'd2};
      clear_list();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset keep count of four: lone maximum, lone minimum, ties and extremes
      queue_item(32'sh7FFF_FFFF, 1'b1);
      queue_item(32'sh8000_0000, 1'b1);
      queue_item(5, 1'b0);
      queue_item(5, 1'b0);
      queue_item(-1, 1'b0);
      queue_item(0, 1'b0);
      queue_item(32'sh7FFF_FFFF, 1'b0);
      queue_item(32'sh8000_0000, 1'b0);
      queue_item(5, 1'b1);
      wait_idle();
      csr_write(REG_KEEP_COUNT, 4'd8);
      csr_write(REG_SPARE, 4'd1);
      // full list with shifting, ties and entries falling off the bottom
      queue_item(-3, 1'b0);
      queue_item(7, 1'b0);
      queue_item(7, 1'b0);
      queue_item(32'sh8000_0000, 1'b0);
      queue_item(32'sh7FFF_FFFF, 1'b0);
      queue_item(0, 1'b0);
      queue_item(7, 1'b0);
      queue_item(-1, 1'b0);
      queue_item(1, 1'b0);
      queue_item(32'sh7FFF_FFFF, 1'b1);

      foreach (keep_plan[ph]) begin
         wait_idle();
         csr_write(REG_KEEP_COUNT, keep_plan[ph]);
         idle_pct  = (ph == 1) ? 0 : 11;
         stall_pct = (ph == 1) ? 0 : 11;
         phase_count = 0;
         if (ph == 1) begin
            // set past the item limit with no idling: latest positions rank highest,
            // the extra one is dropped and carries the last mark
            queue_set(MAX_ITEMS + 1, SCORE_RAMP);
            phase_count = PHASE_ITEMS;
         end
         if (ph == 2) begin
            // long receiver hold-off while short sets keep arriving
            hold_starts <= hold_starts + 1;
            for (int s = 0; s < 6; s++) queue_set($urandom_range(1, 2), SCORE_WIDE);
            phase_count = PHASE_ITEMS;
         end
         while (phase_count < PHASE_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            queue_set(len, score_mode_type'($urandom_range(2)));
            phase_count += len;
         end
      end

      wait_idle();
      if (expected_ranks.size() != 0)
         report_mismatch($sformatf("%0d ranks never arrived", expected_ranks.size()));
      if (mismatches == 0) begin
         $display("** streaming_topk_selector: PASSED **");
      end else begin
         $display("** streaming_topk_selector: FAILED **");
      end
      $finish;
   end

endmodule
